// ===== src/sqga_pkg.sv =====
// shared types, constants and register map of the single qubit gate block
package sqga_pkg;

  localparam int DefMaxQubits = 10;
  localparam int DefAmpWidth  = 16;

  localparam int CoefWidth    = 16;
  localparam int CoefFrac     = CoefWidth - 1;
  localparam int QcWidth      = 4;
  localparam int TargetWidth  = 4;
  localparam int CfgAddrWidth = 3;
  localparam int CfgDataWidth = CoefWidth;

  localparam logic [CfgAddrWidth-1:0] RegQubitCount = 3'd0;
  localparam logic [CfgAddrWidth-1:0] RegTargetBit  = 3'd1;
  localparam logic [CfgAddrWidth-1:0] RegCoefR0C0   = 3'd2;
  localparam logic [CfgAddrWidth-1:0] RegCoefR0C1   = 3'd3;
  localparam logic [CfgAddrWidth-1:0] RegCoefR1C0   = 3'd4;
  localparam logic [CfgAddrWidth-1:0] RegCoefR1C1   = 3'd5;

  localparam logic [QcWidth-1:0]            RstQubitCount = 4'd10;
  localparam logic [TargetWidth-1:0]        RstTargetBit  = 4'd0;
  localparam logic signed [CoefWidth-1:0]   RstCoefR0C0   = 16'sd23170;
  localparam logic signed [CoefWidth-1:0]   RstCoefR0C1   = 16'sd23170;
  localparam logic signed [CoefWidth-1:0]   RstCoefR1C0   = -16'sd23170;
  localparam logic signed [CoefWidth-1:0]   RstCoefR1C1   = 16'sd23170;

  localparam logic ModeLoad    = 1'b0;
  localparam logic ModeCompute = 1'b1;

  typedef struct packed {
    logic [QcWidth-1:0]          qubit_count;
    logic [TargetWidth-1:0]      target_bit;
    logic signed [CoefWidth-1:0] coef_r0c0;
    logic signed [CoefWidth-1:0] coef_r0c1;
    logic signed [CoefWidth-1:0] coef_r1c0;
    logic signed [CoefWidth-1:0] coef_r1c1;
  } cfg_t;

endpackage

// ===== src/sqga_ram.sv =====
// generic ram, one write port and two registered read ports
module sqga_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ===== src/sqga_cfg.sv =====
// configuration registers of the gate block
module sqga_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [sqga_pkg::CfgAddrWidth-1:0] addr_i,
  input  logic [sqga_pkg::CfgDataWidth-1:0] data_i,
  output sqga_pkg::cfg_t                    cfg_o
);
  import sqga_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (addr_i)
        RegQubitCount: cfg_d.qubit_count = data_i[QcWidth-1:0];
        RegTargetBit:  cfg_d.target_bit  = data_i[TargetWidth-1:0];
        RegCoefR0C0:   cfg_d.coef_r0c0   = data_i;
        RegCoefR0C1:   cfg_d.coef_r0c1   = data_i;
        RegCoefR1C0:   cfg_d.coef_r1c0   = data_i;
        RegCoefR1C1:   cfg_d.coef_r1c1   = data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.qubit_count <= RstQubitCount;
      cfg_q.target_bit  <= RstTargetBit;
      cfg_q.coef_r0c0   <= RstCoefR0C0;
      cfg_q.coef_r0c1   <= RstCoefR0C1;
      cfg_q.coef_r1c0   <= RstCoefR1C0;
      cfg_q.coef_r1c1   <= RstCoefR1C1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/sqga_mac.sv =====
// multiply stage and round/saturate output stage of the gate block
module sqga_mac #(
  parameter int IdxWidth = sqga_pkg::DefMaxQubits,
  parameter int AmpWidth = sqga_pkg::DefAmpWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [IdxWidth-1:0]                  in_idx_i,
  input  logic signed [sqga_pkg::CoefWidth-1:0] in_c0_i,
  input  logic signed [sqga_pkg::CoefWidth-1:0] in_c1_i,
  input  logic [2*AmpWidth-1:0]                in_a0_i,
  input  logic [2*AmpWidth-1:0]                in_a1_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [IdxWidth-1:0]                  out_idx_o,
  output logic [AmpWidth-1:0]                  out_re_o,
  output logic [AmpWidth-1:0]                  out_im_o,
  output logic                                 out_sat_o
);
  import sqga_pkg::*;

  localparam int ProdW = CoefWidth + AmpWidth;
  localparam int SumW  = ProdW + 1;
  localparam int RndW  = SumW - CoefFrac;
  localparam logic signed [SumW-1:0] Bias =
    SumW'(64'sd1 <<< (CoefFrac - 1));
  localparam logic signed [RndW-1:0] Hi =
    RndW'((64'sd1 <<< (AmpWidth - 1)) - 64'sd1);
  localparam logic signed [RndW-1:0] Lo = -Hi - RndW'(1);

  logic signed [AmpWidth-1:0] a0_re, a0_im, a1_re, a1_im;
  logic signed [ProdW-1:0]    p0re_q, p1re_q, p0im_q, p1im_q;
  logic [IdxWidth-1:0]        idx2_q;
  logic                       v2_q, v3_q;
  logic                       adv3, adv2;

  logic signed [SumW-1:0] sum_re, sum_im;
  logic signed [RndW-1:0] rnd_re, rnd_im;
  logic [AmpWidth-1:0]    sat_re, sat_im;
  logic                   clip_re, clip_im;

  logic [IdxWidth-1:0]    out_idx_q;
  logic [AmpWidth-1:0]    out_re_q, out_im_q;
  logic                   out_sat_q;

  assign a0_re = in_a0_i[AmpWidth-1:0];
  assign a0_im = in_a0_i[2*AmpWidth-1:AmpWidth];
  assign a1_re = in_a1_i[AmpWidth-1:0];
  assign a1_im = in_a1_i[2*AmpWidth-1:AmpWidth];

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign in_ready_o = adv2;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      p0re_q <= ProdW'(in_c0_i) * ProdW'(a0_re);
      p1re_q <= ProdW'(in_c1_i) * ProdW'(a1_re);
      p0im_q <= ProdW'(in_c0_i) * ProdW'(a0_im);
      p1im_q <= ProdW'(in_c1_i) * ProdW'(a1_im);
      idx2_q <= in_idx_i;
    end
  end

  // exact sum, round half up, clamp
  always_comb begin
    logic signed [SumW-1:0] b_re, b_im;
    sum_re = SumW'(p0re_q) + SumW'(p1re_q);
    sum_im = SumW'(p0im_q) + SumW'(p1im_q);
    b_re   = (sum_re + Bias) >>> CoefFrac;
    b_im   = (sum_im + Bias) >>> CoefFrac;
    rnd_re = b_re[RndW-1:0];
    rnd_im = b_im[RndW-1:0];
    clip_re = (rnd_re > Hi) || (rnd_re < Lo);
    clip_im = (rnd_im > Hi) || (rnd_im < Lo);
    if (rnd_re > Hi) begin
      sat_re = Hi[AmpWidth-1:0];
    end else if (rnd_re < Lo) begin
      sat_re = Lo[AmpWidth-1:0];
    end else begin
      sat_re = rnd_re[AmpWidth-1:0];
    end
    if (rnd_im > Hi) begin
      sat_im = Hi[AmpWidth-1:0];
    end else if (rnd_im < Lo) begin
      sat_im = Lo[AmpWidth-1:0];
    end else begin
      sat_im = rnd_im[AmpWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_idx_q <= idx2_q;
      out_re_q  <= sat_re;
      out_im_q  <= sat_im;
      out_sat_q <= clip_re || clip_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) begin
        v2_q <= in_valid_i;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign out_valid_o = v3_q;
  assign out_idx_o   = out_idx_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign out_sat_o   = out_sat_q;

endmodule

// ===== src/single_qubit_gate_apply.sv =====
// top level: applies a 2x2 real gate to one target bit of a stored state vector
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata index, amp_re, amp_im; tuser mode
//   m_axis    out  m_axis_tvalid/tready      tdata out_index, out_re, out_im; tuser saturated
//   cfg       in   cfg_we_i                  cfg_addr_i, cfg_data_i
//
// one word per cycle on both sides while the output is not stalled; a compute word's
// result goes through ram read at acceptance, multiply, round/saturate; a load gives none
// the amplitude ram has one write and two read ports, so a compute reads both pair
// partners in the cycle it is accepted; a load is written at its acceptance edge
// reset clears control and configuration only; the ram needs no clearing
// a stalled output backs up through the three stages before s_axis_tready drops
module single_qubit_gate_apply #(
  parameter int MAX_QUBITS = sqga_pkg::DefMaxQubits,
  parameter int AMP_WIDTH  = sqga_pkg::DefAmpWidth
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // index, amp_re, amp_im
  input  logic [((MAX_QUBITS+2*AMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic                                        s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // out_index, out_re, out_im
  output logic [((MAX_QUBITS+2*AMP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // saturated
  output logic                                        m_axis_tuser,
  input  logic                                        cfg_we_i,
  input  logic [sqga_pkg::CfgAddrWidth-1:0]           cfg_addr_i,
  input  logic [sqga_pkg::CfgDataWidth-1:0]           cfg_data_i
);
  import sqga_pkg::*;

  localparam int IdxW   = MAX_QUBITS;
  localparam int Depth  = 1 << MAX_QUBITS;
  localparam int FieldW = IdxW + 2 * AMP_WIDTH;
  localparam int DataW  = ((FieldW + 7) / 8) * 8;
  localparam int QcExtW = 6;
  localparam logic [AMP_WIDTH-1:0] AmpHi = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic [AMP_WIDTH-1:0] AmpLo = {1'b1, {(AMP_WIDTH-1){1'b0}}};

  cfg_t cfg;

  logic [IdxW-1:0]      in_index;
  logic [2*AMP_WIDTH-1:0] in_amp;
  logic                 accept, is_compute;
  logic [QcExtW-1:0]    qc_eff;
  logic [IdxW-1:0]      idx_mask, tgt_onehot, idx, i0, i1;
  logic                 row;

  logic                        v1_q;
  logic [IdxW-1:0]             idx1_q;
  logic signed [CoefWidth-1:0] c0_q, c1_q;
  logic [2*AMP_WIDTH-1:0]      a0, a1;
  logic                        mac_ready;

  logic [IdxW-1:0]      out_idx;
  logic [AMP_WIDTH-1:0] out_re, out_im;

  sqga_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .addr_i (cfg_addr_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign in_index = s_axis_tdata[IdxW-1:0];
  assign in_amp   = s_axis_tdata[FieldW-1:IdxW];

  // index mask from clamped qubit count, target bit as one-hot
  always_comb begin
    qc_eff = QcExtW'(cfg.qubit_count);
    if (qc_eff == '0) begin
      qc_eff = QcExtW'(1);
    end else if (qc_eff > QcExtW'(MAX_QUBITS)) begin
      qc_eff = QcExtW'(MAX_QUBITS);
    end
    for (int k = 0; k < IdxW; k++) begin
      idx_mask[k]   = QcExtW'(k) < qc_eff;
      tgt_onehot[k] = QcExtW'(cfg.target_bit) == QcExtW'(k);
    end
  end

  assign idx = in_index & idx_mask;
  assign i0  = idx & ~tgt_onehot;
  assign i1  = (idx | tgt_onehot) & idx_mask;
  assign row = |(idx & tgt_onehot);

  assign s_axis_tready = !v1_q || mac_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_compute    = s_axis_tuser == ModeCompute;

  sqga_ram #(
    .Width (2 * AMP_WIDTH),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (accept && (s_axis_tuser == ModeLoad)),
    .waddr_i   (idx),
    .wdata_i   (in_amp),
    .re_i      (accept && is_compute),
    .raddr_a_i (i0),
    .raddr_b_i (i1),
    .rdata_a_o (a0),
    .rdata_b_o (a1)
  );

  always_ff @(posedge clk_i) begin
    if (accept && is_compute) begin
      idx1_q <= idx;
      c0_q   <= row ? cfg.coef_r1c0 : cfg.coef_r0c0;
      c1_q   <= row ? cfg.coef_r1c1 : cfg.coef_r0c1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= accept && is_compute;
    end
  end

  sqga_mac #(
    .IdxWidth (IdxW),
    .AmpWidth (AMP_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (mac_ready),
    .in_idx_i    (idx1_q),
    .in_c0_i     (c0_q),
    .in_c1_i     (c1_q),
    .in_a0_i     (a0),
    .in_a1_i     (a1),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (out_idx),
    .out_re_o    (out_re),
    .out_im_o    (out_im),
    .out_sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = DataW'({out_im, out_re, out_idx});

  a_sat_flag_means_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (out_re == AmpHi) || (out_re == AmpLo) || (out_im == AmpHi) || (out_im == AmpLo))
    else $error("saturated flag without a clipped part");

  a_stall_only_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output side is free");

  a_compute_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (v1_q == $past(is_compute)))
    else $error("accepted word did not enter the read stage correctly");

endmodule

// ===== tb/sv/single_qubit_gate_apply_test.sv =====
// testbench for single_qubit_gate_apply: streamed load and compute words checked by a gate predictor
module single_qubit_gate_apply_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sqga_pkg::*;

  localparam int IdxWidth    = DefMaxQubits;
  localparam int AmpWidth    = DefAmpWidth;
  localparam int StoreDepth  = 1 << IdxWidth;
  localparam int WordWidth   = ((IdxWidth + 2 * AmpWidth + 7) / 8) * 8;
  localparam int TotalWords  = 1850;
  localparam int CycleLimit  = 400000;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 8;
  localparam logic [CfgAddrWidth-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgAddrWidth-1:0] RegSpare7 = 3'd7;

  typedef struct packed {
    logic                       mode;
    logic [IdxWidth-1:0]        index;
    logic signed [AmpWidth-1:0] re;
    logic signed [AmpWidth-1:0] im;
  } gate_word_t;

  typedef struct packed {
    logic [IdxWidth-1:0]        index;
    logic signed [AmpWidth-1:0] re;
    logic signed [AmpWidth-1:0] im;
    logic                       sat;
  } gate_result_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [WordWidth-1:0]        s_axis_tdata  = '0;
  logic                        s_axis_tuser  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [WordWidth-1:0]        m_axis_tdata;
  logic                        m_axis_tuser;
  logic                        cfg_we_i      = 1'b0;
  logic [CfgAddrWidth-1:0]     cfg_addr_i    = '0;
  logic [CfgDataWidth-1:0]     cfg_data_i    = '0;

  cfg_t gate_cfg = '{RstQubitCount, RstTargetBit, RstCoefR0C0, RstCoefR0C1,
                     RstCoefR1C0, RstCoefR1C1};
  logic signed [AmpWidth-1:0] amp_re_store [StoreDepth];
  logic signed [AmpWidth-1:0] amp_im_store [StoreDepth];
  bit                         loaded       [StoreDepth];

  gate_word_t   words_to_send [$];
  gate_result_t gated_amplitudes_due [$];
  gate_word_t   next_word;
  gate_word_t   taken_word;
  gate_result_t due_amp;

  int words_queued  = 0;
  int words_offered = 0;
  int words_taken   = 0;
  int results_taken = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int send_gap_max  = 0;
  int recv_gap_max  = 0;
  int send_gap      = 0;
  bit send_gap_drawn = 1'b0;
  int recv_gap      = 0;
  int recv_seen     = 0;
  int hold_left     = 0;
  int hold_next     = 0;
  int hold_marks [2] = '{60, 700};

  single_qubit_gate_apply DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [IdxWidth-1:0] live_mask();
    int q;
    q = gate_cfg.qubit_count;
    if (q < 1) q = 1;
    if (q > IdxWidth) q = IdxWidth;
    return IdxWidth'((1 << q) - 1);
  endfunction

  function automatic void pair_partners(input logic [IdxWidth-1:0] raw,
                                        output logic [IdxWidth-1:0] idx, lo, hi,
                                        output logic row);
    logic [15:0]         pw;
    logic [IdxWidth-1:0] m;
    m   = live_mask();
    pw  = 16'd1 << gate_cfg.target_bit;
    idx = raw & m;
    lo  = idx & ~pw[IdxWidth-1:0] & m;
    hi  = (idx | pw[IdxWidth-1:0]) & m;
    row = |(idx & pw[IdxWidth-1:0]);
  endfunction

  // round half up from Q3.30 to Q1.15, then clamp
  function automatic logic signed [AmpWidth-1:0] round_q15(input longint acc,
                                                           inout logic clip);
    longint top;
    longint r;
    top = (longint'(1) <<< (AmpWidth - 1)) - 1;
    r   = (acc + (longint'(1) <<< 14)) >>> 15;
    if (r > top) begin
      clip = 1'b1;
      r = top;
    end else if (r < -top - 1) begin
      clip = 1'b1;
      r = -top - 1;
    end
    return AmpWidth'(r);
  endfunction

  function automatic void apply_gate_word(input gate_word_t w);
    logic [IdxWidth-1:0]         idx, lo, hi;
    logic                        row, clip;
    logic signed [CoefWidth-1:0] c0, c1;
    gate_result_t                r;
    pair_partners(w.index, idx, lo, hi, row);
    if (w.mode == ModeLoad) begin
      amp_re_store[idx] = w.re;
      amp_im_store[idx] = w.im;
    end else begin
      c0    = row ? gate_cfg.coef_r1c0 : gate_cfg.coef_r0c0;
      c1    = row ? gate_cfg.coef_r1c1 : gate_cfg.coef_r0c1;
      clip  = 1'b0;
      r.index = idx;
      r.re  = round_q15(longint'(c0) * amp_re_store[lo] + longint'(c1) * amp_re_store[hi],
                        clip);
      r.im  = round_q15(longint'(c0) * amp_im_store[lo] + longint'(c1) * amp_im_store[hi],
                        clip);
      r.sat = clip;
      gated_amplitudes_due.push_back(r);
    end
  endfunction

  function automatic logic signed [AmpWidth-1:0] rand_amp();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(AmpWidth - 1){1'b0}}};
      1: return {1'b0, {(AmpWidth - 1){1'b1}}};
      2: return AmpWidth'(int'($urandom_range(0, 6)) - 3);
      default: return AmpWidth'($urandom);
    endcase
  endfunction

  function automatic void queue_load(input logic [IdxWidth-1:0] raw,
                                     input logic signed [AmpWidth-1:0] re, im);
    words_to_send.push_back('{mode: ModeLoad, index: raw, re: re, im: im});
    loaded[raw & live_mask()] = 1'b1;
    words_queued++;
  endfunction

  function automatic void queue_compute(input logic [IdxWidth-1:0] raw);
    words_to_send.push_back('{mode: ModeCompute, index: raw,
                              re: AmpWidth'($urandom), im: AmpWidth'($urandom)});
    words_queued++;
  endfunction

  // partners never loaded get a load first; the lower partner's load has junk above the live index bits
  function automatic void queue_random_compute();
    logic [IdxWidth-1:0] raw, idx, lo, hi, junk;
    logic                row;
    raw  = IdxWidth'($urandom);
    junk = IdxWidth'($urandom) & ~live_mask();
    pair_partners(raw, idx, lo, hi, row);
    if (!loaded[lo]) queue_load(lo | junk, rand_amp(), rand_amp());
    if (!loaded[hi]) queue_load(hi, rand_amp(), rand_amp());
    queue_compute(raw);
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  task automatic write_reg(input logic [CfgAddrWidth-1:0] addr,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    case (addr)
      RegQubitCount: gate_cfg.qubit_count = data[QcWidth-1:0];
      RegTargetBit:  gate_cfg.target_bit  = data[TargetWidth-1:0];
      RegCoefR0C0:   gate_cfg.coef_r0c0   = data;
      RegCoefR0C1:   gate_cfg.coef_r0c1   = data;
      RegCoefR1C0:   gate_cfg.coef_r1c0   = data;
      RegCoefR1C1:   gate_cfg.coef_r1c1   = data;
      default: ;
    endcase
  endtask

  task automatic set_gate(input logic [CfgDataWidth-1:0] qc, target, c00, c01, c10, c11);
    write_reg(RegQubitCount, qc);
    write_reg(RegTargetBit, target);
    write_reg(RegCoefR0C0, c00);
    write_reg(RegCoefR0C1, c01);
    write_reg(RegCoefR1C0, c10);
    write_reg(RegCoefR1C1, c11);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_to_send.size() != 0 || words_taken != words_offered ||
           gated_amplitudes_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && words_taken != words_offered)) begin
      if (words_to_send.size() != 0 && !send_gap_drawn) begin
        send_gap       = $urandom_range(0, send_gap_max);
        send_gap_drawn = 1'b1;
      end
      if (words_to_send.size() != 0 && send_gap == 0) begin
        next_word = words_to_send.pop_front();
        s_axis_tdata  <= WordWidth'({next_word.im, next_word.re, next_word.index});
        s_axis_tuser  <= next_word.mode;
        s_axis_tvalid <= 1'b1;
        words_offered++;
        send_gap_drawn = 1'b0;
      end else begin
        if (send_gap > 0) send_gap--;
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken_word.mode  = s_axis_tuser;
      taken_word.index = s_axis_tdata[IdxWidth-1:0];
      taken_word.re    = s_axis_tdata[IdxWidth +: AmpWidth];
      taken_word.im    = s_axis_tdata[IdxWidth + AmpWidth +: AmpWidth];
      apply_gate_word(taken_word);
      words_taken++;
    end
  end

  // output ready: per-word random wait plus two long hold-offs
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left == 0 && hold_next < 2 && results_taken >= hold_marks[hold_next]) begin
        hold_left = LongHold;
        hold_next++;
      end
      if (results_taken != recv_seen) begin
        recv_seen = results_taken;
        recv_gap  = $urandom_range(0, recv_gap_max);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_taken++;
      if (gated_amplitudes_due.size() == 0) begin
        report_mismatch("word with nothing due, out_index", m_axis_tdata[IdxWidth-1:0], -1);
      end else begin
        due_amp = gated_amplitudes_due.pop_front();
        if (m_axis_tdata[IdxWidth-1:0] !== due_amp.index)
          report_mismatch("out_index", m_axis_tdata[IdxWidth-1:0], due_amp.index);
        if (m_axis_tdata[IdxWidth +: AmpWidth] !== due_amp.re)
          report_mismatch("out_re", $signed(m_axis_tdata[IdxWidth +: AmpWidth]), due_amp.re);
        if (m_axis_tdata[IdxWidth + AmpWidth +: AmpWidth] !== due_amp.im)
          report_mismatch("out_im", $signed(m_axis_tdata[IdxWidth + AmpWidth +: AmpWidth]),
                          due_amp.im);
        if (m_axis_tuser !== due_amp.sat)
          report_mismatch("saturated", m_axis_tuser, due_amp.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n;
    logic [QcWidth-1:0] qc;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset gate, all ten qubits, target bit 0: full-scale sums clip
    queue_load(10'd0, 16'sh7fff, 16'sh8000);
    queue_load(10'd1, 16'sh7fff, 16'sh8000);
    queue_compute(10'd0);
    queue_compute(10'd1);
    queue_load(10'd1023, 16'sh8000, 16'sh0000);
    queue_load(10'd1022, 16'sh0000, 16'sh7fff);
    queue_compute(10'd1023);
    queue_compute(10'd1022);
    wait_drained();

    // zero qubit count acts as one; target above the count; spare registers ignored
    set_gate(16'h0000, 16'h0003, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    write_reg(RegSpare6, 16'hffff);
    write_reg(RegSpare7, 16'h0000);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    queue_load(10'h3fe, 16'sh7fff, 16'sh8000);
    queue_compute(10'h2a4);
    queue_load(10'h155, 16'sh8000, 16'sh0001);
    queue_compute(10'h3ff);
    wait_drained();

    // count above the maximum acts as the maximum; rounding at exactly one half
    set_gate(16'hffff, 16'hfff9, 16'sh8000, 16'sh8000, 16'sh0001, 16'shffff);
    queue_load(10'h005, 16'sh8000, 16'sh4000);
    queue_load(10'h205, 16'sh8000, 16'sh0000);
    queue_load(10'h006, 16'sh0001, 16'shc000);
    queue_load(10'h206, 16'sh0000, 16'sh0000);
    queue_compute(10'h005);
    queue_compute(10'h205);
    queue_compute(10'h206);
    wait_drained();

    while (words_queued < TotalWords) begin
      case ($urandom_range(0, 5))
        0: qc = 4'd10;
        1: qc = 4'd0;
        2: qc = 4'd15;
        default: qc = QcWidth'($urandom_range(0, 15));
      endcase
      set_gate({12'($urandom), qc},
               CfgDataWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 9)),
               rand_amp(), rand_amp(), rand_amp(), rand_amp());
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? RegSpare6 : RegSpare7, CfgDataWidth'($urandom));
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
      end
      send_gap_max = pick_gap();
      recv_gap_max = pick_gap();
      n = $urandom_range(60, 200);
      repeat (n) begin
        if ($urandom_range(0, 9) < 3)
          queue_load(IdxWidth'($urandom), rand_amp(), rand_amp());
        else
          queue_random_compute();
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
